### rtl/lcpe_pkg.sv
// Package for the LED chain pulse encoder: request, response, config and status types,
// command/status/register codes and the phase-length helpers.
// No dependencies.
package lcpe_pkg;

    localparam int BITS_PER_LED = 24;
    localparam int WORD_W       = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 9;

    // Timing register reset values, in ticks
    localparam logic [7:0] ONE_HIGH_RESET  = 8'd64;
    localparam logic [7:0] ONE_LOW_RESET   = 8'd36;
    localparam logic [7:0] ZERO_HIGH_RESET = 8'd32;
    localparam logic [7:0] ZERO_LOW_RESET  = 8'd68;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_START = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_BUSY  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_LED_COUNT = 3'd0,
        REG_ONE_HIGH  = 3'd1,
        REG_ONE_LOW   = 3'd2,
        REG_ZERO_HIGH = 3'd3,
        REG_ZERO_LOW  = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CLEAR = 4'b0100,
        S_FRAME = 4'b1000
    } state_t;

    typedef struct packed {
        logic [8:0] led_count;
        logic [7:0] one_high;
        logic [7:0] one_low;
        logic [7:0] zero_high;
        logic [7:0] zero_low;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] pixel_index;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
    } req_t;

    typedef struct packed {
        status_t status;
        logic    line_level;
        logic    busy_res;
        logic    frame_done;
    } rsp_t;

    typedef struct packed {
        state_t state;
        logic   load_pending;
        logic   ram_we;
    } eng_status_t;

    // A programmed length of zero behaves as one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Length of the high or low phase for the given data bit
    function automatic logic [7:0] phase_len(input logic bit_val, input logic high,
                                             input cfg_t cfg);
        logic [7:0] sel;
        if (high)
        begin
            sel = bit_val ? cfg.one_high : cfg.zero_high;
        end
        else
        begin
            sel = bit_val ? cfg.one_low : cfg.zero_low;
        end
        return at_least_one(sel);
    endfunction

endpackage

### rtl/lcpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lcpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lcpe_cfg.sv
// Configuration register file: LED count and the four bit-timing registers.
// Depends on lcpe_pkg.
module lcpe_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lcpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lcpe_pkg::cfg_t                      cfg
);

    lcpe_pkg::cfg_t cfg_reg;
    lcpe_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (lcpe_pkg::reg_index_t'(cfg_index))
                lcpe_pkg::REG_LED_COUNT: cfg_next.led_count = cfg_data;
                lcpe_pkg::REG_ONE_HIGH:  cfg_next.one_high  = cfg_data[7:0];
                lcpe_pkg::REG_ONE_LOW:   cfg_next.one_low   = cfg_data[7:0];
                lcpe_pkg::REG_ZERO_HIGH: cfg_next.zero_high = cfg_data[7:0];
                lcpe_pkg::REG_ZERO_LOW:  cfg_next.zero_low  = cfg_data[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count <= 9'd0;
            cfg_reg.one_high  <= lcpe_pkg::ONE_HIGH_RESET;
            cfg_reg.one_low   <= lcpe_pkg::ONE_LOW_RESET;
            cfg_reg.zero_high <= lcpe_pkg::ZERO_HIGH_RESET;
            cfg_reg.zero_low  <= lcpe_pkg::ZERO_LOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lcpe_engine.sv
// Command engine: pixel store RAM, clear sweeps and the per-tick bit waveform.
// Depends on lcpe_pkg and lcpe_ram.
module lcpe_engine #(
    parameter int MAX_LEDS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  lcpe_pkg::req_t        req,
    input  lcpe_pkg::cfg_t        cfg,
    output logic                  ready,
    output lcpe_pkg::rsp_t        rsp,
    output lcpe_pkg::eng_status_t eng_st
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int PW = $clog2(MAX_LEDS + 1);
    localparam int CW = (PW > 9) ? PW : 9;
    localparam int WW = lcpe_pkg::WORD_W;

    lcpe_pkg::state_t state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [4:0]       bit_reg, bit_next;
    logic             high_reg, high_next;
    logic [7:0]       phase_reg, phase_next;
    logic [WW-1:0]    word_reg, word_next;
    logic             pend_reg, pend_next;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [WW-1:0]    ram_wdata, ram_rdata;

    logic [CW-1:0]    count_ext, eff_count;
    logic [PW-1:0]    pos_inc;
    logic [4:0]       bit_inc;
    logic [WW-1:0]    eff_word, shifted;
    logic [7:0]       eff_phase;

    lcpe_ram #(.WIDTH(WW), .DEPTH(MAX_LEDS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective LED count, clamped to the store depth
    assign count_ext = CW'(cfg.led_count);
    assign eff_count = (count_ext > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : count_ext;
    assign pos_inc   = pos_reg + PW'(1);
    assign bit_inc   = bit_reg + 5'd1;

    // A pixel fetched last cycle is forwarded straight from the RAM output
    assign eff_word  = pend_reg ? ram_rdata : word_reg;
    assign eff_phase = pend_reg ? lcpe_pkg::phase_len(ram_rdata[WW-1], 1'b1, cfg) : phase_reg;
    assign shifted   = {eff_word[WW-2:0], 1'b0};

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        high_next      = high_reg;
        phase_next     = eff_phase;
        word_next      = eff_word;
        pend_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[AW-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = pos_inc[AW-1:0];
        rsp.status     = lcpe_pkg::STATUS_OK;
        rsp.line_level = 1'b0;
        rsp.frame_done = 1'b0;

        unique case (state_reg)
            lcpe_pkg::S_INIT:
            begin
                ram_we = 1'b1;
                if (pos_reg == PW'(MAX_LEDS - 1))
                begin
                    state_next = lcpe_pkg::S_IDLE;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            lcpe_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.cmd)
                        lcpe_pkg::CMD_WRITE:
                        begin
                            if (CW'(req.pixel_index) < eff_count)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(req.pixel_index);
                                ram_wdata = {req.green_value, req.red_value, req.blue_value};
                            end
                            else
                            begin
                                rsp.status = lcpe_pkg::STATUS_RANGE;
                            end
                        end
                        lcpe_pkg::CMD_CLEAR:
                        begin
                            state_next = lcpe_pkg::S_CLEAR;
                            pos_next   = '0;
                        end
                        lcpe_pkg::CMD_START:
                        begin
                            if (eff_count != '0)
                            begin
                                state_next = lcpe_pkg::S_FRAME;
                                pos_next   = '0;
                                bit_next   = 5'd0;
                                high_next  = 1'b1;
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                pend_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            // idle tick: line stays low
                        end
                    endcase
                end
            end

            lcpe_pkg::S_CLEAR:
            begin
                if (req_valid)
                begin
                    if (req.cmd == lcpe_pkg::CMD_TICK)
                    begin
                        ram_we = 1'b1;
                        if (pos_inc == PW'(MAX_LEDS))
                        begin
                            pos_next   = '0;
                            state_next = lcpe_pkg::S_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    else
                    begin
                        rsp.status = lcpe_pkg::STATUS_BUSY;
                    end
                end
            end

            lcpe_pkg::S_FRAME:
            begin
                if (req_valid)
                begin
                    if (req.cmd == lcpe_pkg::CMD_TICK)
                    begin
                        rsp.line_level = high_reg;
                        if (eff_phase > 8'd1)
                        begin
                            phase_next = eff_phase - 8'd1;
                        end
                        else if (high_reg)
                        begin
                            high_next  = 1'b0;
                            phase_next = lcpe_pkg::phase_len(eff_word[WW-1], 1'b0, cfg);
                        end
                        else if (bit_inc < 5'(lcpe_pkg::BITS_PER_LED))
                        begin
                            bit_next   = bit_inc;
                            word_next  = shifted;
                            high_next  = 1'b1;
                            phase_next = lcpe_pkg::phase_len(shifted[WW-1], 1'b1, cfg);
                        end
                        else if (CW'(pos_inc) >= eff_count)
                        begin
                            // last bit of the last pixel
                            state_next     = lcpe_pkg::S_IDLE;
                            pos_next       = '0;
                            bit_next       = 5'd0;
                            high_next      = 1'b0;
                            phase_next     = 8'd0;
                            word_next      = '0;
                            rsp.frame_done = 1'b1;
                        end
                        else
                        begin
                            // fetch the next pixel; word and phase come from the RAM next cycle
                            pos_next  = pos_inc;
                            bit_next  = 5'd0;
                            high_next = 1'b1;
                            ram_re    = 1'b1;
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp.status = lcpe_pkg::STATUS_BUSY;
                    end
                end
            end

            default:
            begin
                state_next = lcpe_pkg::S_IDLE;
            end
        endcase

        rsp.busy_res = (state_next == lcpe_pkg::S_CLEAR) || (state_next == lcpe_pkg::S_FRAME);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcpe_pkg::S_INIT;
            pos_reg   <= '0;
            bit_reg   <= 5'd0;
            high_reg  <= 1'b0;
            phase_reg <= 8'd0;
            word_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bit_reg   <= bit_next;
            high_reg  <= high_next;
            phase_reg <= phase_next;
            word_reg  <= word_next;
            pend_reg  <= pend_next;
        end
    end

    assign ready               = (state_reg != lcpe_pkg::S_INIT);
    assign eng_st.state        = state_reg;
    assign eng_st.load_pending = pend_reg;
    assign eng_st.ram_we       = ram_we;

endmodule

### rtl/rgb_led_chain_pulse_encoder_top.sv
// RGB LED chain pulse encoder, top level. A request's response sits in the
// output register in the cycle after acceptance. Throughput: one request per clock while
// the response is taken; pixel fetches from the store RAM are hidden behind bit timing.
// Reset: config takes its reset values, then the store is zeroed one RAM entry per cycle
// with s_tready low. A clear command sweeps one entry per tick.
// Depends on lcpe_pkg, lcpe_cfg, lcpe_engine, lcpe_ram.
module rgb_led_chain_pulse_encoder_top #(
    parameter int MAX_LEDS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // pixel_index, red_value, green_value, blue_value
    input  logic [1:0]                       s_tuser,   // cmd
    // response stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // status[1:0], line_level, busy_res, zero fill
    output logic                             m_tlast,   // frame_done
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lcpe_pkg::cfg_t        cfg;
    lcpe_pkg::req_t        req;
    lcpe_pkg::rsp_t        rsp;
    lcpe_pkg::eng_status_t eng_st;
    lcpe_pkg::rsp_t        rsp_reg;
    logic                  m_tvalid_reg;
    logic                  eng_ready;
    logic                  req_accept;

    lcpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the request
    assign req.cmd         = lcpe_pkg::cmd_t'(s_tuser);
    assign req.pixel_index = s_tdata[7:0];
    assign req.red_value   = s_tdata[15:8];
    assign req.green_value = s_tdata[23:16];
    assign req.blue_value  = s_tdata[31:24];

    assign s_tready   = eng_ready && (!m_tvalid_reg || m_tready);
    assign req_accept = s_tvalid && s_tready;

    lcpe_engine #(.MAX_LEDS(MAX_LEDS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_accept),
        .req       (req),
        .cfg       (cfg),
        .ready     (eng_ready),
        .rsp       (rsp),
        .eng_st    (eng_st)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, rsp_reg.busy_res, rsp_reg.line_level, rsp_reg.status};
    assign m_tlast  = rsp_reg.frame_done;

    // Frame end always lands in a low phase and leaves the block idle
    a_done_low_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (!m_tdata[2] && !m_tdata[3]))
        else $error("frame_done with line high or busy set");

    // A pixel fetch is only outstanding inside a frame
    a_pend_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        eng_st.load_pending |-> (eng_st.state == lcpe_pkg::S_FRAME))
        else $error("pixel load pending outside a frame");

    // The store is never written while a frame reads it
    a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        eng_st.ram_we |-> (eng_st.state != lcpe_pkg::S_FRAME))
        else $error("pixel store written during a frame");

endmodule

### verif/tb_rgb_led_chain_pulse_encoder_top.sv
// Testbench for rgb_led_chain_pulse_encoder_top: directed and random request streams
// checked against a cycle-free predictor of the pixel store, clear sweep and bit timing.
// Depends on lcpe_pkg and the encoder RTL.
module tb_rgb_led_chain_pulse_encoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LED_MAX    = 256;
    localparam int IDLE_LIMIT = 3000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [lcpe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lcpe_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted encoder state
    logic [23:0] pix_mem [LED_MAX] = '{default: '0};
    int unsigned led_pos    = 0;
    int unsigned bit_pos    = 0;
    int unsigned ticks_left = 0;
    logic        high_phase = 1'b0;
    logic [23:0] shift_w    = '0;
    logic        frame_on   = 1'b0;
    logic        clear_on   = 1'b0;

    // Predicted register contents
    logic [8:0]  cnt_reg = 9'd0;
    logic [7:0]  oh_reg  = lcpe_pkg::ONE_HIGH_RESET;
    logic [7:0]  ol_reg  = lcpe_pkg::ONE_LOW_RESET;
    logic [7:0]  zh_reg  = lcpe_pkg::ZERO_HIGH_RESET;
    logic [7:0]  zl_reg  = lcpe_pkg::ZERO_LOW_RESET;

    lcpe_pkg::rsp_t led_rsp_q [$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [15:0] stall_pat   = 16'hFFFF;
    int          pat_age     = 0;

    rgb_led_chain_pulse_encoder_top #(
        .MAX_LEDS (LED_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned eff_leds();
        return (cnt_reg > LED_MAX) ? LED_MAX : cnt_reg;
    endfunction

    // Load a high or low phase for the bit at the top of the shift word
    function automatic void load_phase(input logic hi);
        logic [7:0] len;
        high_phase = hi;
        if (shift_w[23])
        begin
            len = hi ? oh_reg : ol_reg;
        end
        else
        begin
            len = hi ? zh_reg : zl_reg;
        end
        ticks_left = (len == 8'd0) ? 1 : len;
    endfunction

    function automatic void fetch_pixel();
        shift_w = pix_mem[led_pos % LED_MAX];
        bit_pos = 0;
        load_phase(1'b1);
    endfunction

    // Apply one request to the predicted state and return its response
    function automatic lcpe_pkg::rsp_t step_led_encoder(input lcpe_pkg::cmd_t c,
                                                        input logic [7:0] idx,
                                                        input logic [7:0] red,
                                                        input logic [7:0] green,
                                                        input logic [7:0] blue);
        lcpe_pkg::rsp_t r;
        logic busy;
        busy     = frame_on || clear_on;
        r        = '0;
        r.status = lcpe_pkg::STATUS_OK;
        if (c == lcpe_pkg::CMD_TICK)
        begin
            if (frame_on)
            begin
                r.line_level = high_phase;
                if (ticks_left > 1)
                begin
                    ticks_left--;
                end
                else if (high_phase)
                begin
                    load_phase(1'b0);
                end
                else
                begin
                    bit_pos++;
                    shift_w = shift_w << 1;
                    if (bit_pos < lcpe_pkg::BITS_PER_LED)
                    begin
                        load_phase(1'b1);
                    end
                    else
                    begin
                        // end of a pixel: the count is checked here
                        led_pos++;
                        if (led_pos >= eff_leds())
                        begin
                            frame_on     = 1'b0;
                            led_pos      = 0;
                            bit_pos      = 0;
                            high_phase   = 1'b0;
                            ticks_left   = 0;
                            shift_w      = '0;
                            r.frame_done = 1'b1;
                        end
                        else
                        begin
                            fetch_pixel();
                        end
                    end
                end
            end
            else if (clear_on)
            begin
                pix_mem[led_pos % LED_MAX] = '0;
                led_pos++;
                if (led_pos >= LED_MAX)
                begin
                    led_pos  = 0;
                    clear_on = 1'b0;
                end
            end
        end
        else if (busy)
        begin
            r.status = lcpe_pkg::STATUS_BUSY;
        end
        else if (c == lcpe_pkg::CMD_WRITE)
        begin
            if (idx < eff_leds())
            begin
                pix_mem[idx] = {green, red, blue};
            end
            else
            begin
                r.status = lcpe_pkg::STATUS_RANGE;
            end
        end
        else if (c == lcpe_pkg::CMD_CLEAR)
        begin
            clear_on = 1'b1;
            led_pos  = 0;
        end
        else if (eff_leds() > 0)
        begin
            frame_on = 1'b1;
            led_pos  = 0;
            fetch_pixel();
        end
        r.busy_res = frame_on || clear_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request; bursts of random length with random gaps between
    task automatic send_req(input lcpe_pkg::cmd_t c, input logic [7:0] idx,
                            input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red, idx};
        s_tuser  <= c;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        led_rsp_q.push_back(step_led_encoder(c, idx, red, green, blue));
        burst_left--;
    endtask

    // Random payload for commands that ignore it
    task automatic send_cmd(input lcpe_pkg::cmd_t c);
        send_req(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_write(input logic [7:0] idx);
        send_req(lcpe_pkg::CMD_WRITE, idx, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(lcpe_pkg::CMD_TICK);
    endtask

    // Tick until the predicted frame or clear sweep is over
    task automatic run_until_idle();
        while (frame_on || clear_on)
        begin
            send_cmd(lcpe_pkg::CMD_TICK);
        end
    endtask

    // Stop requesting and wait for every response to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (led_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration side
    // ------------------------------------------------------------------

    task automatic cfg_put(input lcpe_pkg::reg_index_t r, input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (r)
            lcpe_pkg::REG_LED_COUNT: cnt_reg = v;
            lcpe_pkg::REG_ONE_HIGH:  oh_reg  = v[7:0];
            lcpe_pkg::REG_ONE_LOW:   ol_reg  = v[7:0];
            lcpe_pkg::REG_ZERO_HIGH: zh_reg  = v[7:0];
            lcpe_pkg::REG_ZERO_LOW:  zl_reg  = v[7:0];
            default: ;
        endcase
    endtask

    // Write all five registers back to back; only called with no response pending
    task automatic program_regs(input logic [8:0] count, input logic [7:0] oh,
                                input logic [7:0] ol, input logic [7:0] zh,
                                input logic [7:0] zl);
        cfg_put(lcpe_pkg::REG_LED_COUNT, count);
        cfg_put(lcpe_pkg::REG_ONE_HIGH,  {1'b0, oh});
        cfg_put(lcpe_pkg::REG_ONE_LOW,   {1'b0, ol});
        cfg_put(lcpe_pkg::REG_ZERO_HIGH, {1'b0, zh});
        cfg_put(lcpe_pkg::REG_ZERO_LOW,  {1'b0, zl});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: stall pattern, checker, watchdog
    // ------------------------------------------------------------------

    // Receiver stalls follow a rotating pattern, renewed each time pat_age wraps
    always @(posedge clk)
    begin
        if (pat_age == 63)
        begin
            pat_age   <= 0;
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : (16'($urandom_range(0, 16'hFFFF))
                                                        | 16'h0001);
        end
        else
        begin
            pat_age   <= pat_age + 1;
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
        end
        m_tready <= stall_pat[15];
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        lcpe_pkg::rsp_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (led_rsp_q.size() == 0)
            begin
                $error("response with nothing pending: tdata %h tlast %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = led_rsp_q.pop_front();
                if (m_tdata[1:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[2] !== want.line_level)
                begin
                    $error("line_level: expected %0d, got %0d", want.line_level, m_tdata[2]);
                    mismatches++;
                end
                if (m_tdata[3] !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, m_tdata[3]);
                    mismatches++;
                end
                if (m_tlast !== want.frame_done)
                begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && cfg_ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: count zero, so writes are out of range and start is empty
    task automatic test_reset_defaults();
        send_cmd(lcpe_pkg::CMD_TICK);
        send_write(8'd0);
        send_write(8'd255);
        send_cmd(lcpe_pkg::CMD_START);
        send_cmd(lcpe_pkg::CMD_TICK);
        settle();
    endtask

    // Index check at both ends, count above the store size acting as the store size
    task automatic test_pixel_writes();
        program_regs(9'd511, 8'd1, 8'd1, 8'd1, 8'd1);
        send_req(lcpe_pkg::CMD_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_req(lcpe_pkg::CMD_WRITE, 8'd255, 8'h00, 8'h00, 8'h00);
        send_req(lcpe_pkg::CMD_WRITE, 8'd128, 8'hA5, 8'h5A, 8'h3C);
        settle();
        program_regs(9'd2, 8'd1, 8'd1, 8'd1, 8'd1);
        send_write(8'd2);
        send_write(8'd255);
        send_req(lcpe_pkg::CMD_WRITE, 8'd1, 8'h00, 8'hFF, 8'h00);
        send_cmd(lcpe_pkg::CMD_START);
        run_until_idle();
        settle();
    endtask

    // Zero timing registers act as one tick; other commands are busy during a frame
    task automatic test_zero_timing();
        program_regs(9'd2, 8'd0, 8'd0, 8'd0, 8'd0);
        send_req(lcpe_pkg::CMD_WRITE, 8'd0, 8'h0F, 8'hF0, 8'h81);
        send_cmd(lcpe_pkg::CMD_START);
        send_write(8'd1);
        send_cmd(lcpe_pkg::CMD_CLEAR);
        send_cmd(lcpe_pkg::CMD_START);
        run_until_idle();
        settle();
    endtask

    // Longest phases, then timing and count changed while the frame runs
    task automatic test_timing_change_midframe();
        program_regs(9'd1, 8'd255, 8'd255, 8'd255, 8'd255);
        send_req(lcpe_pkg::CMD_WRITE, 8'd0, 8'h01, 8'h80, 8'hFF);
        send_cmd(lcpe_pkg::CMD_START);
        send_ticks(200);
        settle();
        // more LEDs and short phases while pixel 0 is still going out
        program_regs(9'd3, 8'd1, 8'd2, 8'd2, 8'd1);
        run_until_idle();
        settle();
        program_regs(9'd4, 8'd1, 8'd1, 8'd1, 8'd1);
        send_cmd(lcpe_pkg::CMD_START);
        send_ticks(30);
        settle();
        // count dropped to zero: the frame ends after the current pixel
        program_regs(9'd0, 8'd1, 8'd1, 8'd1, 8'd1);
        run_until_idle();
        settle();
    endtask

    // Clear sweep zeroes the store; commands during it are busy
    task automatic test_clear_sweep();
        program_regs(9'd3, 8'd1, 8'd2, 8'd3, 8'd1);
        send_req(lcpe_pkg::CMD_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_write(8'd1);
        send_write(8'd2);
        send_cmd(lcpe_pkg::CMD_CLEAR);
        send_write(8'd0);
        send_cmd(lcpe_pkg::CMD_START);
        send_cmd(lcpe_pkg::CMD_CLEAR);
        run_until_idle();
        send_cmd(lcpe_pkg::CMD_START);
        run_until_idle();
        settle();
    endtask

    // Count at the store size: the top index is writable; a lower count cuts the frame short
    task automatic test_full_chain();
        program_regs(9'd256, 8'd1, 8'd1, 8'd1, 8'd1);
        send_req(lcpe_pkg::CMD_WRITE, 8'd255, 8'hC3, 8'h3C, 8'h99);
        send_write(8'd17);
        send_cmd(lcpe_pkg::CMD_START);
        send_ticks(60);
        settle();
        // the frame stops at the end of the pixel now going out
        program_regs(9'd2, 8'd1, 8'd1, 8'd1, 8'd1);
        run_until_idle();
        settle();
    endtask

    // Random phases: well-formed write/start/tick sequences with busy noise and clears
    task automatic test_random_traffic();
        int          sent;
        int          n_ops;
        int          roll;
        int unsigned leds;
        logic [8:0]  count;
        sent = 0;
        while (sent < 400)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                count = 9'($urandom_range(1, 3));
            end
            else if (roll == 7)
            begin
                count = 9'd0;
            end
            else
            begin
                count = 9'($urandom_range(0, 511));
            end
            // registers change between phases, often while a frame is still running
            if ($urandom_range(0, 9) == 0)
            begin
                program_regs(count, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                program_regs(count, 8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                             8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)));
            end
            n_ops = $urandom_range(10, 120);
            for (int k = 0; k < n_ops; k++)
            begin
                if (frame_on || clear_on)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_cmd(lcpe_pkg::cmd_t'(2'($urandom_range(0, 2))));
                    end
                    else
                    begin
                        send_cmd(lcpe_pkg::CMD_TICK);
                    end
                end
                else
                begin
                    roll = $urandom_range(0, 19);
                    leds = eff_leds();
                    if (roll < 10)
                    begin
                        if (leds > 0 && roll < 8)
                        begin
                            send_write(8'($urandom_range(0, leds - 1)));
                        end
                        else
                        begin
                            send_write(8'($urandom_range(0, 255)));
                        end
                    end
                    else if (roll < 15)
                    begin
                        send_cmd(lcpe_pkg::CMD_START);
                    end
                    else if (roll == 15)
                    begin
                        send_cmd(lcpe_pkg::CMD_CLEAR);
                    end
                    else
                    begin
                        send_cmd(lcpe_pkg::CMD_TICK);
                    end
                end
                sent++;
            end
            settle();
        end
        // wind down whatever is still running
        program_regs(9'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        run_until_idle();
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_pixel_writes();
        test_zero_timing();
        test_timing_change_midframe();
        test_clear_sweep();
        test_full_chain();
        test_random_traffic();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
